@@ sv/imu_pkg.sv @@
// Shared types and constants for the Ising Metropolis update unit.
`timescale 1ns / 1ps

package imu_pkg;

   // Fixed field widths of the transfer payloads
   localparam int SITE_W         = 6;
   localparam int FRAC_W         = 16;
   localparam int ENERGY_W       = 15;
   localparam int MAGNET_W       = 14;
   localparam int ENERGY_DELTA_W = 5;
   localparam int MAGNET_DELTA_W = 3;
   localparam int CSR_INDEX_W    = 2;

   // Operation codes carried in req_tuser
   localparam logic FUNC_SET     = 1'b0;
   localparam logic FUNC_ATTEMPT = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_SMALL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_LARGE = 2'd1;

   // The site spin and its four wrapped neighbors (1 = +1)
   typedef struct packed {
      logic site;
      logic up;
      logic dn;
      logic lf;
      logic rt;
   } nbhd_type;

   // Outcome of one item
   typedef struct packed {
      logic                              flip;
      logic                              new_spin;
      logic signed [ENERGY_DELTA_W-1:0]  energy_delta;
      logic signed [MAGNET_DELTA_W-1:0]  magnet_delta;
   } flip_decision_type;

endpackage

@@ sv/ising_metropolis_update_unit.sv @@
// Top level of the 2D Ising single-spin-flip Metropolis update unit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   req     | in        | req_tvalid/req_tready  | tuser: func; tdata: site, rand, spin
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata: flipped, spin, energy, magnet
//   csr     | in        | csr_valid/csr_ready    | csr_index, csr_wdata (thresholds)
//
// One item per cycle sustained while rsp_tready stays high; the req item passes through the
// input register, the spin row read and the decision into the result register
// before rsp_tvalid rises.
// The spins live in three copies of a row memory (one word per row), so the rows
// above, at and below the site are read together; a row written by the item
// ahead at the same edge is forwarded.
// After reset a clearing pass writes all spins up, one row per cycle, over all GRID_ROWS
// rows; req_tready stays low meanwhile. csr writes are always taken.
// A stalled rsp holds the pipeline; nothing is dropped.
`timescale 1ns / 1ps

module ising_metropolis_update_unit #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // site_row[5:0], site_col[11:6], rand_fraction[27:12],
                                    // spin_value[28], zero fill
   input  logic        req_tuser,   // func
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // flipped[0], site_spin[1], total_energy[16:2],
                                    // total_magnetisation[30:17], zero fill
   // csr
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [imu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [imu_pkg::FRAC_W-1:0]      csr_wdata
);

   localparam int RW        = $clog2(GRID_ROWS);
   localparam int CW        = $clog2(GRID_COLS);
   localparam int SITE_SPAN = 2 ** imu_pkg::SITE_W;
   localparam int EW        = imu_pkg::ENERGY_W;
   localparam int MW        = imu_pkg::MAGNET_W;
   localparam int EDW       = imu_pkg::ENERGY_DELTA_W;
   localparam int MDW       = imu_pkg::MAGNET_DELTA_W;
   localparam logic [EW-1:0] ENERGY_INIT = EW'(0 - 2 * GRID_ROWS * GRID_COLS);
   localparam logic [MW-1:0] MAGNET_INIT = MW'(GRID_ROWS * GRID_COLS);
   localparam logic [RW-1:0] ROW_LAST    = RW'(GRID_ROWS - 1);
   localparam logic [CW-1:0] COL_LAST    = CW'(GRID_COLS - 1);

   // Input fields
   logic [imu_pkg::SITE_W-1:0] in_row;
   logic [imu_pkg::SITE_W-1:0] in_col;
   logic [imu_pkg::FRAC_W-1:0] in_rand;
   logic                       in_want;

   assign in_row  = req_tdata[5:0];
   assign in_col  = req_tdata[11:6];
   assign in_rand = req_tdata[27:12];
   assign in_want = req_tdata[28];

   // Constant wrap tables: site index modulo the grid size
   logic [RW-1:0] row_wrap [SITE_SPAN];
   logic [CW-1:0] col_wrap [SITE_SPAN];

   for (genvar i = 0; i < SITE_SPAN; i++) begin : g_wrap
      assign row_wrap[i] = RW'(i % GRID_ROWS);
      assign col_wrap[i] = CW'(i % GRID_COLS);
   end

   // Control
   logic clr_active_ff, clr_active_in;
   logic [RW-1:0] clr_row_ff, clr_row_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, s1_advance, s2_advance, item_write;

   // Configuration
   logic [imu_pkg::FRAC_W-1:0] thr_small_ff, thr_small_in;
   logic [imu_pkg::FRAC_W-1:0] thr_large_ff, thr_large_in;

   // Running counters
   logic [EW-1:0] energy_ff, energy_in;
   logic [MW-1:0] magnet_ff, magnet_in;

   // Stage 1: captured item
   logic                       s1_func_ff, s1_want_ff;
   logic [RW-1:0]              s1_row_ff;
   logic [CW-1:0]              s1_col_ff;
   logic [imu_pkg::FRAC_W-1:0] s1_rand_ff;
   logic [RW-1:0]              s1_up, s1_dn;

   // Stage 2: item plus the three rows read
   logic                       s2_func_ff, s2_want_ff;
   logic [RW-1:0]              s2_row_ff, s2_up_ff, s2_dn_ff;
   logic [CW-1:0]              s2_col_ff;
   logic [imu_pkg::FRAC_W-1:0] s2_rand_ff;
   logic [GRID_COLS-1:0]       rd_up_ff, rd_mid_ff, rd_dn_ff;
   logic [CW-1:0]              s2_lf, s2_rt;

   // Row written at the edge the stage 2 item was read
   logic                       fwd_valid_ff;
   logic [RW-1:0]              fwd_row_ff;
   logic [GRID_COLS-1:0]       fwd_data_ff;

   logic [GRID_COLS-1:0]       up_eff, mid_eff, dn_eff, new_row;

   // Spin memories (three identical copies)
   logic [GRID_COLS-1:0] mem_up  [GRID_ROWS];
   logic [GRID_COLS-1:0] mem_mid [GRID_ROWS];
   logic [GRID_COLS-1:0] mem_dn  [GRID_ROWS];
   logic                 mem_we;
   logic [RW-1:0]        mem_waddr;
   logic [GRID_COLS-1:0] mem_wdata;

   imu_pkg::nbhd_type          nbhd;
   imu_pkg::flip_decision_type dec;

   // Result register
   logic          rsp_flip_ff, rsp_spin_ff;
   logic [EW-1:0] rsp_energy_ff;
   logic [MW-1:0] rsp_magnet_ff;

   // Handshakes: each stage advances when the one after it is free or moving
   assign s2_advance = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s1_advance = s1_valid_ff && (!s2_valid_ff || s2_advance);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign item_write = s2_advance && dec.flip;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s1_advance ? 1'b1 : (s2_advance ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = s2_advance ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0
                                                                         : rsp_valid_ff);

   // Clearing pass after reset
   assign clr_active_in = clr_active_ff && (clr_row_ff != ROW_LAST);
   assign clr_row_in    = clr_active_ff ? clr_row_ff + 1'b1 : clr_row_ff;

   // Configuration writes; unknown indexes are dropped
   always_comb begin
      thr_small_in = thr_small_ff;
      thr_large_in = thr_large_ff;
      if (csr_valid) begin
         case (csr_index)
            imu_pkg::CSR_THRESH_SMALL: thr_small_in = csr_wdata;
            imu_pkg::CSR_THRESH_LARGE: thr_large_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         thr_small_ff  <= '0;
         thr_large_ff  <= '0;
         energy_ff     <= ENERGY_INIT;
         magnet_ff     <= MAGNET_INIT;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_row_ff    <= clr_row_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         thr_small_ff  <= thr_small_in;
         thr_large_ff  <= thr_large_in;
         energy_ff     <= energy_in;
         magnet_ff     <= magnet_in;
         if (s1_advance) begin
            fwd_valid_ff <= item_write;
         end
      end
   end

   // Stage 1: capture the item with the site wrapped onto the grid
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff <= req_tuser;
         s1_want_ff <= in_want;
         s1_row_ff  <= row_wrap[in_row];
         s1_col_ff  <= col_wrap[in_col];
         s1_rand_ff <= in_rand;
      end
   end

   assign s1_up = (s1_row_ff == '0) ? ROW_LAST : s1_row_ff - 1'b1;
   assign s1_dn = (s1_row_ff == ROW_LAST) ? '0 : s1_row_ff + 1'b1;

   // Stage 2 payload and forwarding snapshot
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_func_ff  <= s1_func_ff;
         s2_want_ff  <= s1_want_ff;
         s2_row_ff   <= s1_row_ff;
         s2_up_ff    <= s1_up;
         s2_dn_ff    <= s1_dn;
         s2_col_ff   <= s1_col_ff;
         s2_rand_ff  <= s1_rand_ff;
         fwd_row_ff  <= s2_row_ff;
         fwd_data_ff <= new_row;
      end
   end

   // Memory write: clearing pass, else the row of a flipped site
   assign mem_we    = clr_active_ff || item_write;
   assign mem_waddr = clr_active_ff ? clr_row_ff : s2_row_ff;
   assign mem_wdata = clr_active_ff ? '1 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_up[mem_waddr] <= mem_wdata;
      end
      if (s1_advance) begin
         rd_up_ff <= mem_up[s1_up];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_mid[mem_waddr] <= mem_wdata;
      end
      if (s1_advance) begin
         rd_mid_ff <= mem_mid[s1_row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_dn[mem_waddr] <= mem_wdata;
      end
      if (s1_advance) begin
         rd_dn_ff <= mem_dn[s1_dn];
      end
   end

   // Replace any row written by the item ahead at the edge of the read
   assign up_eff  = (fwd_valid_ff && fwd_row_ff == s2_up_ff)  ? fwd_data_ff : rd_up_ff;
   assign mid_eff = (fwd_valid_ff && fwd_row_ff == s2_row_ff) ? fwd_data_ff : rd_mid_ff;
   assign dn_eff  = (fwd_valid_ff && fwd_row_ff == s2_dn_ff)  ? fwd_data_ff : rd_dn_ff;

   assign s2_lf = (s2_col_ff == '0) ? COL_LAST : s2_col_ff - 1'b1;
   assign s2_rt = (s2_col_ff == COL_LAST) ? '0 : s2_col_ff + 1'b1;

   assign nbhd.site = mid_eff[s2_col_ff];
   assign nbhd.up   = up_eff[s2_col_ff];
   assign nbhd.dn   = dn_eff[s2_col_ff];
   assign nbhd.lf   = mid_eff[s2_lf];
   assign nbhd.rt   = mid_eff[s2_rt];

   imu_flip_decide u_decide (
      .nbhd          (nbhd),
      .func          (s2_func_ff),
      .want_spin     (s2_want_ff),
      .rand_fraction (s2_rand_ff),
      .thresh_small  (thr_small_ff),
      .thresh_large  (thr_large_ff),
      .decision      (dec)
   );

   always_comb begin
      new_row            = mid_eff;
      new_row[s2_col_ff] = dec.new_spin;
   end

   // Counters move only on a flip; both wrap at their widths
   always_comb begin
      energy_in = energy_ff;
      magnet_in = magnet_ff;
      if (item_write) begin
         energy_in = energy_ff + {{(EW - EDW){dec.energy_delta[EDW-1]}}, dec.energy_delta};
         magnet_in = magnet_ff + {{(MW - MDW){dec.magnet_delta[MDW-1]}}, dec.magnet_delta};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (s2_advance) begin
         rsp_flip_ff   <= dec.flip;
         rsp_spin_ff   <= dec.new_spin;
         rsp_energy_ff <= energy_in;
         rsp_magnet_ff <= magnet_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_magnet_ff, rsp_energy_ff, rsp_spin_ff, rsp_flip_ff};

   // Every flip moves the magnetization by two, so its low bit never changes
   a_magnet_parity: assert property (@(posedge clock) disable iff (reset)
      magnet_ff[0] == MAGNET_INIT[0])
      else $error("magnetization parity lost");

   // Energy steps are multiples of four
   a_energy_step: assert property (@(posedge clock) disable iff (reset)
      energy_ff[1:0] == ENERGY_INIT[1:0])
      else $error("energy moved by a step that is not a multiple of four");

   // Counters hold when an item leaves the site unchanged
   a_hold_no_flip: assert property (@(posedge clock) disable iff (reset)
      (s2_advance && !dec.flip) |=> ($stable(energy_ff) && $stable(magnet_ff)))
      else $error("counters moved without a flip");

   // A flip always moves the magnetization
   a_flip_moves: assert property (@(posedge clock) disable iff (reset)
      item_write |=> (magnet_ff != $past(magnet_ff)))
      else $error("flip left magnetization unchanged");

   // No item is in flight during the clearing pass
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("item in flight while the spin store is cleared");

endmodule

@@ sv/imu_flip_decide.sv @@
// Metropolis acceptance and counter deltas for one site.
`timescale 1ns / 1ps

module imu_flip_decide (
   input  imu_pkg::nbhd_type                  nbhd,
   input  logic                               func,
   input  logic                               want_spin,
   input  logic [imu_pkg::FRAC_W-1:0]         rand_fraction,
   input  logic [imu_pkg::FRAC_W-1:0]         thresh_small,
   input  logic [imu_pkg::FRAC_W-1:0]         thresh_large,
   output imu_pkg::flip_decision_type         decision
);

   logic [2:0]              aligned;
   logic signed [5:0]       de_wide;
   logic                    flip;

   // Neighbors that agree with the site; dE = 4*aligned - 8
   assign aligned = 3'(nbhd.up == nbhd.site) + 3'(nbhd.dn == nbhd.site)
                  + 3'(nbhd.lf == nbhd.site) + 3'(nbhd.rt == nbhd.site);
   assign de_wide = $signed({1'b0, aligned, 2'b00}) - 6'sd8;

   always_comb begin
      if (func == imu_pkg::FUNC_ATTEMPT) begin
         case (aligned)
            3'd3:    flip = thresh_small > rand_fraction;
            3'd4:    flip = thresh_large > rand_fraction;
            default: flip = 1'b1;   // energy does not rise
         endcase
      end else begin
         flip = want_spin != nbhd.site;
      end
   end

   assign decision.flip         = flip;
   assign decision.new_spin     = nbhd.site ^ flip;
   assign decision.energy_delta = de_wide[imu_pkg::ENERGY_DELTA_W-1:0];
   // New spin up adds two, new spin down takes two away
   assign decision.magnet_delta = nbhd.site ? -3'sd2 : 3'sd2;

endmodule
